>>> src/owpsc_pkg.sv
package owpsc_pkg;

    localparam int NUM_WHEELS  = 4;
    localparam int VEL_W       = 15;
    localparam int SPEED_W     = 16;
    localparam int GAIN_W      = 8;
    localparam int INTEG_W     = 11;
    localparam int DUTY_W      = 10;
    localparam int CFG_IDX_W   = 2;

    localparam int COEF_Q15    = 23170;
    localparam int Q_SHIFT     = 15;
    localparam int INTEG_LIMIT = 999;
    localparam int DRIVE_LIMIT = 999;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;

    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef logic signed [VEL_W-1:0]   t_vel;
    typedef logic signed [SPEED_W-1:0] t_speed;
    typedef logic signed [INTEG_W-1:0] t_integ;
    typedef logic [GAIN_W-1:0]         t_gain;
    typedef logic [DUTY_W-1:0]         t_duty;

endpackage

>>> src/omni_wheel_pi_speed_control_unit.sv
// Path: a tick beat passes the input register, then the result register, and can
// leave from there; a stalled output holds it back. A command beat gives no result and
// updates the setpoints as it leaves the input register.
// Throughput: one beat per cycle while the output side keeps up; the kinematics and PI datapath are combinational.
// Reset (synchronous, active low): clears valids, setpoints and integrals, and loads the
// gains with 55 and 13. Configuration writes are always taken and need no warm-up.
module omni_wheel_pi_speed_control_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_action,
    input  owpsc_pkg::t_vel                      i_vel_x,
    input  owpsc_pkg::t_vel                      i_vel_y,
    input  owpsc_pkg::t_vel                      i_vel_rot,
    input  owpsc_pkg::t_speed                    i_meas_speed_0,
    input  owpsc_pkg::t_speed                    i_meas_speed_1,
    input  owpsc_pkg::t_speed                    i_meas_speed_2,
    input  owpsc_pkg::t_speed                    i_meas_speed_3,

    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_fwd_0,
    output logic                                 o_fwd_1,
    output logic                                 o_fwd_2,
    output logic                                 o_fwd_3,
    output owpsc_pkg::t_duty                     o_duty_0,
    output owpsc_pkg::t_duty                     o_duty_1,
    output owpsc_pkg::t_duty                     o_duty_2,
    output owpsc_pkg::t_duty                     o_duty_3,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [owpsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  owpsc_pkg::t_gain                     i_cfg_data
);

    // Input stage registers. Only the valid flag is reset.
    logic                r_in_valid;
    logic                r_action;
    owpsc_pkg::t_vel     r_vel_x;
    owpsc_pkg::t_vel     r_vel_y;
    owpsc_pkg::t_vel     r_vel_rot;
    owpsc_pkg::t_speed   r_meas [owpsc_pkg::NUM_WHEELS];

    // Block state: gains, wheel setpoints and per-wheel integrals.
    owpsc_pkg::t_gain    r_prop_gain;
    owpsc_pkg::t_gain    r_integ_gain;
    owpsc_pkg::t_speed   r_setpoint [owpsc_pkg::NUM_WHEELS];
    owpsc_pkg::t_integ   r_integ [owpsc_pkg::NUM_WHEELS];

    // Result register.
    logic                r_out_valid;
    logic                r_fwd [owpsc_pkg::NUM_WHEELS];
    owpsc_pkg::t_duty    r_duty [owpsc_pkg::NUM_WHEELS];

    owpsc_pkg::t_speed   sp_new [owpsc_pkg::NUM_WHEELS];
    owpsc_pkg::t_integ   n_integ [owpsc_pkg::NUM_WHEELS];
    logic                n_fwd [owpsc_pkg::NUM_WHEELS];
    owpsc_pkg::t_duty    n_duty [owpsc_pkg::NUM_WHEELS];

    logic                out_free;
    logic                stage_adv;
    logic                in_fire;
    logic                is_tick;

    // The result register is free when empty or when its beat leaves this cycle.
    // The input stage moves forward whenever the result register is free, so the
    // block keeps taking one beat per cycle while the downstream side keeps up.
    assign out_free  = !r_out_valid || i_ready;
    assign stage_adv = r_in_valid && out_free;
    assign o_ready   = !r_in_valid || out_free;
    assign in_fire   = i_valid && o_ready;
    assign is_tick   = (r_action == owpsc_pkg::ACT_TICK);

    // Configuration writes should only happen while idle; the block does not enforce this and always accepts them.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= owpsc_pkg::GAIN_W'(55);
            r_integ_gain <= owpsc_pkg::GAIN_W'(13);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                owpsc_pkg::CFG_PROP_GAIN: begin
                    r_prop_gain <= i_cfg_data;
                end
                owpsc_pkg::CFG_INTEG_GAIN: begin
                    r_integ_gain <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action  <= i_action;
            r_vel_x   <= i_vel_x;
            r_vel_y   <= i_vel_y;
            r_vel_rot <= i_vel_rot;
            r_meas[0] <= i_meas_speed_0;
            r_meas[1] <= i_meas_speed_1;
            r_meas[2] <= i_meas_speed_2;
            r_meas[3] <= i_meas_speed_3;
        end
    end

    // Inverse kinematics of the registered command.
    owpsc_kinematics u_kinematics (
        .i_vel_x   (r_vel_x),
        .i_vel_y   (r_vel_y),
        .i_vel_rot (r_vel_rot),
        .o_sp_0    (sp_new[0]),
        .o_sp_1    (sp_new[1]),
        .o_sp_2    (sp_new[2]),
        .o_sp_3    (sp_new[3])
    );

    // One PI loop per wheel, all working on the same tick in parallel.
    for (genvar w = 0; w < owpsc_pkg::NUM_WHEELS; w++) begin : g_wheel
        owpsc_wheel_pi u_wheel_pi (
            .i_setpoint   (r_setpoint[w]),
            .i_meas       (r_meas[w]),
            .i_integ      (r_integ[w]),
            .i_prop_gain  (r_prop_gain),
            .i_integ_gain (r_integ_gain),
            .o_integ      (n_integ[w]),
            .o_fwd        (n_fwd[w]),
            .o_duty       (n_duty[w])
        );

        // A command beat replaces the setpoints; a tick beat advances the integral.
        // Both happen as the beat leaves the input stage, so the next beat already
        // sees the updated state.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_setpoint[w] <= '0;
                r_integ[w]    <= '0;
            end else if (stage_adv) begin
                if (is_tick) begin
                    r_integ[w] <= n_integ[w];
                end else begin
                    r_setpoint[w] <= sp_new[w];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (stage_adv && is_tick) begin
                r_fwd[w]  <= n_fwd[w];
                r_duty[w] <= n_duty[w];
            end
        end
    end

    // Only tick beats produce a result; command beats are absorbed here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= stage_adv && is_tick;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_fwd_0  = r_fwd[0];
    assign o_fwd_1  = r_fwd[1];
    assign o_fwd_2  = r_fwd[2];
    assign o_fwd_3  = r_fwd[3];
    assign o_duty_0 = r_duty[0];
    assign o_duty_1 = r_duty[1];
    assign o_duty_2 = r_duty[2];
    assign o_duty_3 = r_duty[3];

endmodule

>>> src/owpsc_kinematics.sv
// Body velocity to wheel setpoints for a 45 degree omni layout.
module owpsc_kinematics (
    input  owpsc_pkg::t_vel   i_vel_x,
    input  owpsc_pkg::t_vel   i_vel_y,
    input  owpsc_pkg::t_vel   i_vel_rot,
    output owpsc_pkg::t_speed o_sp_0,
    output owpsc_pkg::t_speed o_sp_1,
    output owpsc_pkg::t_speed o_sp_2,
    output owpsc_pkg::t_speed o_sp_3
);

    localparam int SUM_W  = owpsc_pkg::VEL_W + 2;
    localparam int PROD_W = 2 * SUM_W;
    localparam logic signed [SUM_W-1:0] COEF = SUM_W'(owpsc_pkg::COEF_Q15);
    localparam logic signed [PROD_W-1:0] SP_MAX = PROD_W'(2 ** (owpsc_pkg::SPEED_W - 1) - 1);
    localparam logic signed [PROD_W-1:0] SP_MIN = -PROD_W'(2 ** (owpsc_pkg::SPEED_W - 1));

    logic signed [SUM_W-1:0]  sum_xy;
    logic signed [SUM_W-1:0]  diff_yx;
    logic signed [PROD_W-1:0] prod_sum;
    logic signed [PROD_W-1:0] prod_diff;

    // Scales by the Q15 coefficient, adds the rotation, then divides by 2^15
    // rounding toward zero and saturates to the setpoint width.
    function automatic owpsc_pkg::t_speed wheel_from(
        input logic signed [PROD_W-1:0] prod,
        input owpsc_pkg::t_vel          rot
    );
        logic signed [PROD_W-1:0] acc;
        logic signed [PROD_W-1:0] quo;
        acc = prod + (PROD_W'(rot) <<< owpsc_pkg::Q_SHIFT);
        quo = acc >>> owpsc_pkg::Q_SHIFT;
        if (acc[PROD_W-1] && (acc[owpsc_pkg::Q_SHIFT-1:0] != '0)) begin
            quo = quo + PROD_W'(1);
        end
        if (quo > SP_MAX) begin
            quo = SP_MAX;
        end else if (quo < SP_MIN) begin
            quo = SP_MIN;
        end
        return quo[owpsc_pkg::SPEED_W-1:0];
    endfunction

    assign sum_xy    = SUM_W'(i_vel_x) + SUM_W'(i_vel_y);
    assign diff_yx   = SUM_W'(i_vel_y) - SUM_W'(i_vel_x);
    assign prod_sum  = PROD_W'(COEF * sum_xy);
    assign prod_diff = PROD_W'(COEF * diff_yx);

    assign o_sp_0 = wheel_from(prod_diff, i_vel_rot);
    assign o_sp_1 = wheel_from(prod_sum, i_vel_rot);
    assign o_sp_2 = wheel_from(-prod_sum, i_vel_rot);
    assign o_sp_3 = wheel_from(-prod_diff, i_vel_rot);

endmodule

>>> src/owpsc_wheel_pi.sv
// One wheel of the speed loop: error, clamped integral, drive and its sign split.
module owpsc_wheel_pi (
    input  owpsc_pkg::t_speed i_setpoint,
    input  owpsc_pkg::t_speed i_meas,
    input  owpsc_pkg::t_integ i_integ,
    input  owpsc_pkg::t_gain  i_prop_gain,
    input  owpsc_pkg::t_gain  i_integ_gain,
    output owpsc_pkg::t_integ o_integ,
    output logic              o_fwd,
    output owpsc_pkg::t_duty  o_duty
);

    localparam int ERR_W   = owpsc_pkg::SPEED_W + 1;
    localparam int PROD_W  = ERR_W + owpsc_pkg::GAIN_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] I_LIM = ACC_W'(owpsc_pkg::INTEG_LIMIT);
    localparam logic signed [ACC_W-1:0] D_LIM = ACC_W'(owpsc_pkg::DRIVE_LIMIT);
    localparam logic [ACC_W-1:0] DUTY_MAX = ACC_W'(2 ** owpsc_pkg::DUTY_W - 1);

    logic signed [ERR_W-1:0]  err;
    logic signed [PROD_W-1:0] i_prod;
    logic signed [PROD_W-1:0] p_prod;
    logic signed [ACC_W-1:0]  integ_raw;
    logic signed [ACC_W-1:0]  integ_clamp;
    logic signed [ACC_W-1:0]  drive_raw;
    logic signed [ACC_W-1:0]  drive;
    logic [ACC_W-1:0]         mag;

    assign err    = ERR_W'(i_setpoint) - ERR_W'(i_meas);
    assign i_prod = PROD_W'($signed({1'b0, i_integ_gain}) * err);
    assign p_prod = PROD_W'($signed({1'b0, i_prop_gain}) * err);

    always_comb begin
        integ_raw = ACC_W'(i_prod) + ACC_W'(i_integ);
        if (integ_raw > I_LIM) begin
            integ_clamp = I_LIM;
        end else if (integ_raw < -I_LIM) begin
            integ_clamp = -I_LIM;
        end else begin
            integ_clamp = integ_raw;
        end

        drive_raw = ACC_W'(p_prod) + integ_clamp + ACC_W'(i_meas);
        if (drive_raw > D_LIM) begin
            drive = D_LIM;
        end else if (drive_raw < -D_LIM) begin
            drive = -D_LIM;
        end else begin
            drive = drive_raw;
        end

        mag = drive[ACC_W-1] ? ACC_W'(-drive) : ACC_W'(drive);
    end

    // Forward only for a strictly positive drive: sign bit clear and not zero.
    assign o_integ = integ_clamp[owpsc_pkg::INTEG_W-1:0];
    assign o_fwd   = !drive[ACC_W-1] && (drive != '0);
    assign o_duty  = (mag > DUTY_MAX) ? owpsc_pkg::DUTY_W'(DUTY_MAX)
                                      : mag[owpsc_pkg::DUTY_W-1:0];

endmodule
